FILE: hw/rtl/tddr_pkg.sv
// ----------------------------------------------------------------------------
// tddr_pkg
// Shared types, widths and codes of the table-driven DFA recognizer.
// ----------------------------------------------------------------------------
package tddr_pkg;

   // Automaton size.
   localparam int STATE_COUNT  = 128;
   localparam int SYMBOL_COUNT = 16;

   // Field widths of the request and response items.
   localparam int MODE_W   = 3;
   localparam int STATE_W  = 8;
   localparam int SLOT_W   = 4;
   localparam int CHAR_W   = 8;
   localparam int COUNT_W  = 5;
   localparam int OUTCOME_W = 2;

   // Derived storage widths.
   localparam int STATE_IDX_W  = $clog2(STATE_COUNT);
   localparam int SLOT_IDX_W   = $clog2(SYMBOL_COUNT);
   localparam int TRANS_DEPTH  = STATE_COUNT * SYMBOL_COUNT;
   localparam int TRANS_ADDR_W = $clog2(TRANS_DEPTH);

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [STATE_W-1:0] INIT_STATE_RESET = STATE_W'(1);
   localparam logic [COUNT_W-1:0] SYM_COUNT_RESET  = COUNT_W'(1);
   localparam logic [STATE_W-1:0] NO_TRANSITION    = '0;

   typedef enum logic [MODE_W-1:0] {
      MODE_SYMBOL = 3'd0,
      MODE_TRANS  = 3'd1,
      MODE_ACCEPT = 3'd2,
      MODE_CHAR   = 3'd3,
      MODE_END    = 3'd4
   } mode_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUTCOME_ACCEPTED  = 2'd0,
      OUTCOME_NONACCEPT = 2'd1,
      OUTCOME_UNKNOWN   = 2'd2,
      OUTCOME_MISSING   = 2'd3
   } outcome_type;

   typedef enum logic [CSR_ADDR_W-3:0] {
      REG_INITIAL_STATE = 1'd0,
      REG_SYMBOL_COUNT  = 1'd1
   } reg_index_type;

endpackage

FILE: hw/rtl/tddr_if.sv
// ----------------------------------------------------------------------------
// tddr_req_if / tddr_rsp_if
// Valid/ready channels carrying request items and response items.
// ----------------------------------------------------------------------------
interface tddr_req_if;
   logic                         valid;
   logic                         ready;
   logic [tddr_pkg::MODE_W-1:0]  mode;
   logic [tddr_pkg::STATE_W-1:0] state_number;
   logic [tddr_pkg::SLOT_W-1:0]  symbol_slot;
   logic [tddr_pkg::STATE_W-1:0] next_state;
   logic                         accept_flag;
   logic [tddr_pkg::CHAR_W-1:0]  character;

   modport source (
      output valid, mode, state_number, symbol_slot, next_state, accept_flag, character,
      input  ready
   );
   modport sink (
      input  valid, mode, state_number, symbol_slot, next_state, accept_flag, character,
      output ready
   );
endinterface

interface tddr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           accepted;
   logic [tddr_pkg::OUTCOME_W-1:0] outcome;
   logic [tddr_pkg::STATE_W-1:0]   final_state;

   modport source (
      output valid, accepted, outcome, final_state,
      input  ready
   );
   modport sink (
      input  valid, accepted, outcome, final_state,
      output ready
   );
endinterface

FILE: hw/rtl/table_driven_dfa_recognizer.sv
// ----------------------------------------------------------------------------
// table_driven_dfa_recognizer
// Load items and unused modes are handled in IDLE alone. A character that steps
// the automaton also passes through STEP, which consumes the transition memory
// read whose data the next character needs; a character that is ignored or
// rejected at once stays in IDLE. An end item reads the accepting-set memory in
// IDLE and RESULT loads the response register from that read, waiting while
// the response register is still occupied.
// Synchronous active-high reset: initial state 1, symbol count 1, accepting set
// empty (valid bits cleared at once); symbol and transition tables are not reset.
// ----------------------------------------------------------------------------
module table_driven_dfa_recognizer (
   input  logic                              clock,
   input  logic                              reset,
   tddr_req_if.sink                          req,
   tddr_rsp_if.source                        rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tddr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tddr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tddr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   // The sequencer has three steps. IDLE takes a transfer. STEP consumes the
   // transition memory read that a character issued. RESULT consumes the
   // accepting-set read that an end item issued and loads the response register.
   typedef enum logic [1:0] {
      S_IDLE,
      S_STEP,
      S_RESULT
   } seq_state_type;

   seq_state_type state_ff, state_in;

   // Configuration registers.
   logic [tddr_pkg::STATE_W-1:0] init_state_ff, init_state_in;
   logic [tddr_pkg::COUNT_W-1:0] sym_count_ff, sym_count_in;

   // Automaton state.
   logic [tddr_pkg::STATE_W-1:0]   cur_state_ff, cur_state_in;
   logic                           rejected_ff, rejected_in;
   logic [tddr_pkg::OUTCOME_W-1:0] cause_ff, cause_in;
   logic                           st_ok_ff, st_ok_in;

   // The alphabet is small and every entry is compared in parallel, so it
   // lives in flip-flops.
   logic [tddr_pkg::CHAR_W-1:0] sym_table_ff [tddr_pkg::SYMBOL_COUNT];
   logic [tddr_pkg::CHAR_W-1:0] sym_table_in [tddr_pkg::SYMBOL_COUNT];

   // Accepting set: a one-bit memory plus a valid bit per state. A state whose
   // valid bit is clear reads as not accepting, which gives the reset value.
   logic                               acc_mem [tddr_pkg::STATE_COUNT];
   logic [tddr_pkg::STATE_COUNT-1:0]   acc_vld_ff, acc_vld_in;
   logic                               acc_we, acc_re;
   logic [tddr_pkg::STATE_IDX_W-1:0]   acc_addr;
   logic                               acc_rdata_ff;
   logic                               acc_vld_rd_ff;

   // Transition memory, single port, with a registered read.
   logic [tddr_pkg::STATE_W-1:0]      trans_mem [tddr_pkg::TRANS_DEPTH];
   logic                              trans_we, trans_re;
   logic [tddr_pkg::TRANS_ADDR_W-1:0] trans_addr;
   logic [tddr_pkg::STATE_W-1:0]      trans_rdata_ff;

   // Response register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_accepted_ff, rsp_accepted_in;
   logic [tddr_pkg::OUTCOME_W-1:0] rsp_outcome_ff, rsp_outcome_in;
   logic [tddr_pkg::STATE_W-1:0]   rsp_final_ff, rsp_final_in;

   // Request decode.
   logic                             req_fire;
   logic                             req_st_ok;
   logic                             req_slot_ok;
   logic [tddr_pkg::STATE_IDX_W-1:0] req_st_idx;
   logic [tddr_pkg::SLOT_IDX_W-1:0]  req_slot_idx;

   // Symbol lookup and current-state checks.
   logic                             sym_found;
   logic [tddr_pkg::SLOT_IDX_W-1:0]  sym_slot;
   logic                             cur_ok;
   logic [tddr_pkg::STATE_IDX_W-1:0] cur_idx;

   // Configuration write strobe and register index.
   logic                          csr_write;
   tddr_pkg::reg_index_type       csr_index;
   logic [tddr_pkg::OUTCOME_W-1:0] end_outcome;
   logic                          rsp_free;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = tddr_pkg::reg_index_type'(csr_paddr[tddr_pkg::CSR_ADDR_W-1:2]);

   always_comb begin
      case (csr_index)
         tddr_pkg::REG_INITIAL_STATE:
            csr_prdata = tddr_pkg::CSR_DATA_W'(init_state_ff);
         tddr_pkg::REG_SYMBOL_COUNT:
            csr_prdata = tddr_pkg::CSR_DATA_W'(sym_count_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // New transfers are taken only in IDLE. A finished response may still wait
   // in the response register meanwhile; only an end item has to wait for it.
   assign req.ready = (state_ff == S_IDLE);
   assign req_fire  = req.valid && req.ready;

   assign req_st_ok   = (int'(req.state_number) >= 1) &&
                        (int'(req.state_number) <= tddr_pkg::STATE_COUNT);
   assign req_slot_ok = int'(req.symbol_slot) < tddr_pkg::SYMBOL_COUNT;
   assign req_st_idx  = tddr_pkg::STATE_IDX_W'(req.state_number - tddr_pkg::STATE_W'(1));
   assign req_slot_idx = tddr_pkg::SLOT_IDX_W'(req.symbol_slot);

   assign cur_ok  = (int'(cur_state_ff) >= 1) && (int'(cur_state_ff) <= tddr_pkg::STATE_COUNT);
   assign cur_idx = tddr_pkg::STATE_IDX_W'(cur_state_ff - tddr_pkg::STATE_W'(1));

   // Parallel compare against all slots in use. The scan runs downward so that
   // the lowest matching slot wins when a byte is stored twice.
   always_comb begin
      sym_found = 1'b0;
      sym_slot  = '0;
      for (int i = tddr_pkg::SYMBOL_COUNT - 1; i >= 0; i--) begin
         if ((i < int'(sym_count_ff)) && (sym_table_ff[i] == req.character)) begin
            sym_found = 1'b1;
            sym_slot  = tddr_pkg::SLOT_IDX_W'(i);
         end
      end
   end

   // Outcome of an end item, formed from the accepting-set read.
   always_comb begin
      if (rejected_ff) begin
         end_outcome = cause_ff;
      end else if (st_ok_ff && acc_vld_rd_ff && acc_rdata_ff) begin
         end_outcome = tddr_pkg::OUTCOME_ACCEPTED;
      end else begin
         end_outcome = tddr_pkg::OUTCOME_NONACCEPT;
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in        = state_ff;
      init_state_in   = init_state_ff;
      sym_count_in    = sym_count_ff;
      cur_state_in    = cur_state_ff;
      rejected_in     = rejected_ff;
      cause_in        = cause_ff;
      st_ok_in        = st_ok_ff;
      sym_table_in    = sym_table_ff;
      acc_vld_in      = acc_vld_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_outcome_in  = rsp_outcome_ff;
      rsp_final_in    = rsp_final_ff;
      acc_we          = 1'b0;
      acc_re          = 1'b0;
      acc_addr        = req_st_idx;
      trans_we        = 1'b0;
      trans_re        = 1'b0;
      trans_addr      = tddr_pkg::TRANS_ADDR_W'(req_st_idx) *
                        tddr_pkg::TRANS_ADDR_W'(tddr_pkg::SYMBOL_COUNT) +
                        tddr_pkg::TRANS_ADDR_W'(req_slot_idx);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req.mode)
                  tddr_pkg::MODE_SYMBOL: begin
                     if (req_slot_ok) begin
                        sym_table_in[req_slot_idx] = req.character;
                     end
                  end
                  tddr_pkg::MODE_TRANS: begin
                     trans_we = req_st_ok && req_slot_ok;
                  end
                  tddr_pkg::MODE_ACCEPT: begin
                     if (req_st_ok) begin
                        acc_we                 = 1'b1;
                        acc_vld_in[req_st_idx] = 1'b1;
                     end
                  end
                  tddr_pkg::MODE_CHAR: begin
                     // After a rejection the string is dead until its end item.
                     // An unknown byte or a current state outside the table
                     // rejects at once; otherwise the transition entry is read
                     // and checked in the next cycle.
                     trans_addr = tddr_pkg::TRANS_ADDR_W'(cur_idx) *
                                  tddr_pkg::TRANS_ADDR_W'(tddr_pkg::SYMBOL_COUNT) +
                                  tddr_pkg::TRANS_ADDR_W'(sym_slot);
                     if (!rejected_ff) begin
                        if (!sym_found) begin
                           rejected_in = 1'b1;
                           cause_in    = tddr_pkg::OUTCOME_UNKNOWN;
                        end else if (!cur_ok) begin
                           rejected_in = 1'b1;
                           cause_in    = tddr_pkg::OUTCOME_MISSING;
                        end else begin
                           trans_re = 1'b1;
                           state_in = S_STEP;
                        end
                     end
                  end
                  tddr_pkg::MODE_END: begin
                     // Read the accepting mark of the current state; whether
                     // that state is in range at all is kept beside the read.
                     acc_re   = 1'b1;
                     acc_addr = cur_idx;
                     st_ok_in = cur_ok;
                     state_in = S_RESULT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_STEP: begin
            if (trans_rdata_ff == tddr_pkg::NO_TRANSITION) begin
               rejected_in = 1'b1;
               cause_in    = tddr_pkg::OUTCOME_MISSING;
            end else begin
               cur_state_in = trans_rdata_ff;
            end
            state_in = S_IDLE;
         end
         S_RESULT: begin
            // Hold here until the response register can take the result, then
            // restart the string from the initial state.
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_accepted_in = (end_outcome == tddr_pkg::OUTCOME_ACCEPTED);
               rsp_outcome_in  = end_outcome;
               rsp_final_in    = cur_state_ff;
               cur_state_in    = init_state_ff;
               rejected_in     = 1'b0;
               cause_in        = tddr_pkg::OUTCOME_ACCEPTED;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The user must write configuration only while the block is idle; the block
      // does not enforce this. Writing the initial state also restarts the string.
      if (csr_write) begin
         case (csr_index)
            tddr_pkg::REG_INITIAL_STATE: begin
               init_state_in = csr_pwdata[tddr_pkg::STATE_W-1:0];
               cur_state_in  = csr_pwdata[tddr_pkg::STATE_W-1:0];
               rejected_in   = 1'b0;
               cause_in      = tddr_pkg::OUTCOME_ACCEPTED;
            end
            tddr_pkg::REG_SYMBOL_COUNT: begin
               sym_count_in = csr_pwdata[tddr_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         init_state_ff <= tddr_pkg::INIT_STATE_RESET;
         sym_count_ff  <= tddr_pkg::SYM_COUNT_RESET;
         cur_state_ff  <= tddr_pkg::INIT_STATE_RESET;
         rejected_ff   <= 1'b0;
         cause_ff      <= tddr_pkg::OUTCOME_ACCEPTED;
         acc_vld_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_state_ff <= init_state_in;
         sym_count_ff  <= sym_count_in;
         cur_state_ff  <= cur_state_in;
         rejected_ff   <= rejected_in;
         cause_ff      <= cause_in;
         acc_vld_ff    <= acc_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      st_ok_ff        <= st_ok_in;
      sym_table_ff    <= sym_table_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_outcome_ff  <= rsp_outcome_in;
      rsp_final_ff    <= rsp_final_in;
   end

   // Transition memory. Writes and reads never share a cycle.
   always_ff @(posedge clock) begin
      if (trans_we) begin
         trans_mem[trans_addr] <= req.next_state;
      end
      if (trans_re) begin
         trans_rdata_ff <= trans_mem[trans_addr];
      end
   end

   // Accepting-set memory and its valid bit, read together.
   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_addr] <= req.accept_flag;
      end
      if (acc_re) begin
         acc_rdata_ff  <= acc_mem[acc_addr];
         acc_vld_rd_ff <= acc_vld_ff[acc_addr];
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.accepted    = rsp_accepted_ff;
   assign rsp.outcome     = rsp_outcome_ff;
   assign rsp.final_state = rsp_final_ff;

endmodule
